// ===== sv/calc_object_nibble_crc_parser_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CALC_OBJECT_NIBBLE_CRC_PARSER_DEFINES_SVH
`define CALC_OBJECT_NIBBLE_CRC_PARSER_DEFINES_SVH

// Check a property while reset is released.
`define CNC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define CNC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cnc_pkg.sv =====
package cnc_pkg;

    localparam int BUFFER_BITS_DEF = 64;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int SKIP_W   = 21;
    localparam int CRC_W    = 16;
    localparam int TOTAL_W  = 24;
    localparam int PROLOG_W = 20;
    localparam int LEN_W    = 8;

    localparam logic [15:0] CRC_POLY_STEP = 16'h1081;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_SIZE  = 3'd1;
    localparam logic [2:0] MODE_ASCIC = 3'd2;
    localparam logic [2:0] MODE_ASCIX = 3'd3;
    localparam logic [2:0] MODE_DIR   = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_LEFTOVER = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic [SKIP_W-1:0] skip;
    } t_prolog_dec;

    function automatic t_prolog_dec prolog_decode(input logic [PROLOG_W-1:0] p);
        t_prolog_dec d;
        d.mode = MODE_NONE;
        d.skip = SKIP_W'(5);
        unique case (p)
            20'h029e8, 20'h02a0a, 20'h02a2c, 20'h02a4e, 20'h02b1e,
            20'h02b40, 20'h02b62, 20'h02b88, 20'h02dcc: d.mode = MODE_SIZE;
            20'h02e48, 20'h02e6d, 20'h02afc:            d.mode = MODE_ASCIC;
            20'h02a96: begin
                d.mode = MODE_DIR;
                d.skip = SKIP_W'(8);
            end
            20'h02911: d.skip = SKIP_W'(10);
            20'h02933: d.skip = SKIP_W'(21);
            20'h02955: d.skip = SKIP_W'(26);
            20'h02977: d.skip = SKIP_W'(37);
            20'h0299d: d.skip = SKIP_W'(47);
            20'h029bf: d.skip = SKIP_W'(7);
            20'h02e92: d.skip = SKIP_W'(11);
            default:   d.skip = SKIP_W'(5);
        endcase
        return d;
    endfunction

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [3:0] nib);
        logic [3:0]       k;
        logic [CRC_W-1:0] prod;
        k    = crc[3:0] ^ nib;
        prod = CRC_W'(CRC_POLY_STEP * {12'b0, k});
        return (crc >> 4) ^ prod;
    endfunction

endpackage

// ===== sv/calc_object_nibble_crc_parser.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | i_valid / o_ready  | i_data_byte, i_last_byte
// out     | output    | o_valid / i_ready  | o_crc_value, o_nibble_total,
//         |           |                    | o_error_code, o_is_final
//
// An accepted beat goes through the parse step, the pop step and the final step; the
// pop step pops N nibbles (0 to BUFFER_BITS/4), one a cycle through the single CRC step
// unit. The final step loads the output register and returns to idle. o_ready is high only in idle.
// A finished result waits in an output register, so the next beat is taken meanwhile;
// a stalled result holds the sequencer in its final step until the register frees.
// Reset (i_rst_n low, synchronous) clears buffer, CRC, count, mode and errors.
module calc_object_nibble_crc_parser
    import cnc_pkg::*;
#(
    parameter int BUFFER_BITS = BUFFER_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CRC_W-1:0]   o_crc_value,
    output logic [TOTAL_W-1:0] o_nibble_total,
    output logic [1:0]         o_error_code,
    output logic               o_is_final
);

    localparam int FILL_W = $clog2(BUFFER_BITS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_POP   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [BUFFER_BITS-1:0] r_buf, n_buf;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [2:0]             r_mode, n_mode;
    logic [SKIP_W-1:0]      r_skip, n_skip;
    logic [CRC_W-1:0]       r_crc, n_crc;
    logic [COUNT_BITS-1:0]  r_cnt, n_cnt;
    logic [1:0]             r_err, n_err;
    logic                   r_last, n_last;
    logic                   r_ovalid, n_ovalid;
    logic                   w_load;

    logic [CRC_W-1:0]       r_out_crc;
    logic [COUNT_BITS-1:0]  r_out_cnt;
    logic [1:0]             r_out_err;
    logic                   r_out_final;
    logic [COUNT_BITS+TOTAL_W-1:0] w_cnt_ext;

    t_prolog_dec w_dec;

    assign w_dec = prolog_decode(r_buf[PROLOG_W-1:0]);

    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_fill   = r_fill;
        n_mode   = r_mode;
        n_skip   = r_skip;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_ready;
        w_load   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_last = i_last_byte;
                    if (r_fill > FILL_W'(BUFFER_BITS - 8)) begin
                        // drop the beat, keep the first error
                        if (r_err == ERR_NONE) n_err = ERR_OVERFLOW;
                    end else begin
                        n_buf  = r_buf | ({{(BUFFER_BITS-8){1'b0}}, i_data_byte} << r_fill);
                        n_fill = r_fill + FILL_W'(8);
                    end
                    n_state = ST_PARSE;
                end
            end
            ST_PARSE: begin
                if (r_skip == '0) begin
                    unique case (r_mode)
                        MODE_SIZE: begin
                            if (r_fill >= FILL_W'(20)) begin
                                n_mode = MODE_NONE;
                                n_skip = SKIP_W'(r_buf[PROLOG_W-1:0]);
                            end
                        end
                        MODE_ASCIC: begin
                            if (r_fill >= FILL_W'(8)) begin
                                n_mode = MODE_NONE;
                                n_skip = SKIP_W'(2) + SKIP_W'({r_buf[LEN_W-1:0], 1'b0});
                            end
                        end
                        MODE_ASCIX: begin
                            if (r_fill >= FILL_W'(8)) begin
                                n_mode = MODE_NONE;
                                n_skip = SKIP_W'(4) + SKIP_W'({r_buf[LEN_W-1:0], 1'b0});
                            end
                        end
                        MODE_DIR: begin
                            if (r_fill >= FILL_W'(20)) begin
                                n_mode = MODE_ASCIX;
                                n_skip = SKIP_W'(r_buf[PROLOG_W-1:0]);
                            end
                        end
                        default: begin
                            n_mode = MODE_NONE;
                            if (r_fill >= FILL_W'(20)) begin
                                n_mode = w_dec.mode;
                                n_skip = w_dec.skip;
                            end
                        end
                    endcase
                end
                n_state = ST_POP;
            end
            ST_POP: begin
                if (r_skip != '0 && r_fill >= FILL_W'(4)) begin
                    n_buf  = r_buf >> 4;
                    n_fill = r_fill - FILL_W'(4);
                    n_crc  = crc_step(r_crc, r_buf[3:0]);
                    n_skip = r_skip - SKIP_W'(1);
                    if (r_cnt != '1) n_cnt = r_cnt + COUNT_BITS'(1);
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_ovalid || i_ready) begin
                    if (r_last && r_buf != '0 && r_err == ERR_NONE) n_err = ERR_LEFTOVER;
                    w_load   = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_buf    <= '0;
            r_fill   <= '0;
            r_mode   <= MODE_NONE;
            r_skip   <= '0;
            r_crc    <= '0;
            r_cnt    <= '0;
            r_err    <= ERR_NONE;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_buf    <= n_buf;
            r_fill   <= n_fill;
            r_mode   <= n_mode;
            r_skip   <= n_skip;
            r_crc    <= n_crc;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_crc   <= r_crc;
            r_out_cnt   <= r_cnt;
            r_out_err   <= n_err;
            r_out_final <= r_last;
        end
    end

    assign w_cnt_ext = {{TOTAL_W{1'b0}}, r_out_cnt};

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_ovalid;
    assign o_crc_value    = r_out_crc;
    assign o_nibble_total = w_cnt_ext[TOTAL_W-1:0];
    assign o_error_code   = r_out_err;
    assign o_is_final     = r_out_final;

endmodule

// ===== sv/cnc_checker.sv =====
`include "calc_object_nibble_crc_parser_defines.svh"

module cnc_checker
    import cnc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [7:0]         i_data_byte,
    input logic               i_last_byte,
    input logic               o_valid,
    input logic               i_ready,
    input logic [CRC_W-1:0]   o_crc_value,
    input logic [TOTAL_W-1:0] o_nibble_total,
    input logic [1:0]         o_error_code,
    input logic               o_is_final
);

    // Track the last delivered beat: a latched error must stick.
    logic               r_seen;
    logic [1:0]         r_prev_err;
    logic               w_sticky_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_prev_err   <= ERR_NONE;
        end else if (o_valid && i_ready) begin
            r_seen       <= 1'b1;
            r_prev_err   <= o_error_code;
        end
    end

    assign w_sticky_ok = !r_seen || r_prev_err == ERR_NONE || o_error_code == r_prev_err;

    `CNC_ASSERT_ALWAYS(a_no_valid_after_reset, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")
    `CNC_ASSERT(a_err_sticky, i_clk, i_rst_n, o_valid |-> w_sticky_ok, "latched error changed")
    `CNC_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped while stalled")
    `CNC_ASSERT(a_hold_crc, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_crc_value) && $stable(o_nibble_total), "stalled result changed")

    logic w_unused;
    assign w_unused = ^{i_valid, o_ready, i_data_byte, i_last_byte, o_is_final};

endmodule

bind calc_object_nibble_crc_parser cnc_checker u_cnc_checker (.*);
